[design/kct_pkg.sv]
// Shared types and codes for the keyed count table.
// Holds the beat structs, command and status codes and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kct_pkg;

  localparam int INDEX_W = 6;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_TAKE   = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_SORT   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_ZERO      = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_SAT       = 3'd4,
    STAT_BAD_INDEX = 3'd5
  } status_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOOK,
    OP_UPDATE,
    OP_APPEND,
    OP_REMOVE,
    OP_SORT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     by_index;
    logic     take;
    logic     odd;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [15:0]        item_key;
    logic [INDEX_W-1:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [15:0] out_key;
    logic [15:0] out_quantity;
    logic [6:0]  entries_in_use;
  } out_item_t;

endpackage

`default_nettype wire

[design/keyed_count_table.sv]
// Sequence: add, take, remove and read go through compare, two gather stages and apply;
// sort runs its transposition phases and then apply; unused command codes go straight to apply.
// One command at a time: in_ready is high only in idle, which the sequencer re-enters once
// apply has committed the result, and apply waits while the output register is still full.
// Reset (rst_n, synchronous, active low) empties the table and the output register;
// entry contents are not cleared and are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none

module keyed_count_table import kct_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(TABLE_DEPTH);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // The sequencer walks each command through its steps. A lookup broadcasts
  // the key (or index) to all cells, which latch a hit flag; the gather tree
  // then reduces the single hit into key, count and position in two registered
  // stages, and the apply step decides the status and tells the cells what to
  // do. Sort runs odd-even transposition phases along the chain.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_GATH1,
    S_GATH2,
    S_SORT,
    S_APPLY
  } state_t;

  state_t                 state_r, state_nxt;
  logic [2:0]             cmd_r, cmd_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [INDEX_W-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]          used_r, used_nxt;
  logic [CW-1:0]          phase_r, phase_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  cell_ctrl_t             ctrl;
  logic [TABLE_DEPTH-1:0] hit_w;
  logic [TABLE_DEPTH-1:0] swap_w;
  logic [KEY_WIDTH-1:0]   key_w   [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] count_w [TABLE_DEPTH];

  logic                   g_found;
  logic [KEY_WIDTH-1:0]   g_key;
  logic [COUNT_WIDTH-1:0] g_count;
  logic [PW-1:0]          g_pos;

  logic                   accept;
  logic                   commit;
  out_item_t              result;
  cell_op_e               apply_op;

  assign accept = in_valid && in_ready;
  // A result is only committed when the output register is free or draining.
  assign commit = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  // The chain of cells. Each cell sees its neighbors' key and count so that
  // remove can shift entries down and sort can swap adjacent pairs.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   lkey;
    logic [COUNT_WIDTH-1:0] lcnt;
    logic                   lswap;
    logic [KEY_WIDTH-1:0]   rkey;
    logic [COUNT_WIDTH-1:0] rcnt;

    if (i == 0) begin : g_left_edge
      assign lkey  = '0;
      assign lcnt  = '0;
      assign lswap = 1'b0;
    end else begin : g_left
      assign lkey  = key_w[i-1];
      assign lcnt  = count_w[i-1];
      assign lswap = swap_w[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_right_edge
      assign rkey = '0;
      assign rcnt = '0;
    end else begin : g_right
      assign rkey = key_w[i+1];
      assign rcnt = count_w[i+1];
    end

    kct_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH),
      .CELL_IDX    (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .cmp_key     (key_r),
      .rd_index    (idx_r),
      .used        (used_r),
      .pos         (g_pos),
      .left_key    (lkey),
      .left_count  (lcnt),
      .left_swap   (lswap),
      .right_key   (rkey),
      .right_count (rcnt),
      .key         (key_w[i]),
      .count       (count_w[i]),
      .swap        (swap_w[i]),
      .hit         (hit_w[i])
    );
  end

  kct_gather #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_gather (
    .clk    (clk),
    .hits   (hit_w),
    .keys   (key_w),
    .counts (count_w),
    .found  (g_found),
    .key    (g_key),
    .count  (g_count),
    .pos    (g_pos)
  );

  // Decide the result beat and the cell operation from the gathered entry.
  always_comb begin
    result                = '0;
    result.entries_in_use = 7'(used_r);
    apply_op              = OP_HOLD;
    used_nxt              = used_r;
    case (cmd_r)
      CMD_ADD: begin
        result.out_key = 16'(key_r);
        if (g_found) begin
          result.found = 1'b1;
          apply_op     = OP_UPDATE;
          if (g_count == COUNT_MAX) begin
            result.status       = STAT_SAT;
            result.out_quantity = 16'(COUNT_MAX);
          end else begin
            result.out_quantity = 16'(g_count + COUNT_WIDTH'(1));
          end
        end else if (used_r == CW'(TABLE_DEPTH)) begin
          result.status = STAT_FULL;
        end else begin
          apply_op              = OP_APPEND;
          used_nxt              = used_r + CW'(1);
          result.out_quantity   = 16'd1;
          result.entries_in_use = 7'(used_r + CW'(1));
        end
      end
      CMD_TAKE: begin
        result.out_key = 16'(key_r);
        if (!g_found) begin
          result.status = STAT_NOT_FOUND;
        end else begin
          result.found = 1'b1;
          if (g_count == '0) begin
            result.status = STAT_ZERO;
          end else begin
            apply_op            = OP_UPDATE;
            result.out_quantity = 16'(g_count - COUNT_WIDTH'(1));
          end
        end
      end
      CMD_REMOVE: begin
        result.out_key = 16'(key_r);
        if (!g_found) begin
          result.status = STAT_NOT_FOUND;
        end else begin
          result.found          = 1'b1;
          apply_op              = OP_REMOVE;
          used_nxt              = used_r - CW'(1);
          result.entries_in_use = 7'(used_r - CW'(1));
        end
      end
      CMD_READ: begin
        if (g_found) begin
          result.found        = 1'b1;
          result.out_key      = 16'(g_key);
          result.out_quantity = 16'(g_count);
        end else begin
          result.status = STAT_BAD_INDEX;
        end
      end
      default: begin
      end
    endcase
  end

  // Cell control is decoded from the sequencer state, the command and the sort phase.
  always_comb begin
    ctrl          = '0;
    ctrl.op       = OP_HOLD;
    ctrl.by_index = (cmd_r == CMD_READ);
    ctrl.take     = (cmd_r == CMD_TAKE);
    ctrl.odd      = phase_r[0];
    case (state_r)
      S_LOOK:  ctrl.op = OP_LOOK;
      S_SORT:  ctrl.op = OP_SORT;
      S_APPLY: ctrl.op = commit ? apply_op : OP_HOLD;
      default: ctrl.op = OP_HOLD;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_data.command;
          key_nxt   = KEY_WIDTH'(in_data.item_key);
          idx_nxt   = in_data.entry_index;
          phase_nxt = '0;
          case (in_data.command)
            CMD_ADD, CMD_TAKE, CMD_REMOVE, CMD_READ: state_nxt = S_LOOK;
            CMD_SORT: state_nxt = S_SORT;
            default:  state_nxt = S_APPLY;
          endcase
        end
      end
      S_LOOK:  state_nxt = S_GATH1;
      S_GATH1: state_nxt = S_GATH2;
      S_GATH2: state_nxt = S_APPLY;
      S_SORT: begin
        // Transposition sort needs as many phases as there are live entries.
        phase_nxt = phase_r + CW'(1);
        if ((phase_r + CW'(1)) >= used_r) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= commit ? used_nxt : used_r;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // Live keys are unique, so a lookup never hits more than one cell.
  a_single_hit : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(hit_w) <= 1)
    else $error("more than one cell matched a lookup");

  a_used_bound : assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_used_on_commit : assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(used_r) |-> $past(state_r == S_APPLY))
    else $error("entry count changed outside the apply step");

  a_result_from_apply : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_APPLY))
    else $error("result beat raised outside the apply step");
`endif

endmodule

`default_nettype wire

[design/kct_cell.sv]
// One entry of the keyed count table chain: key, count and a match flag.
// Depends on kct_pkg for the cell control struct, the cell operations and INDEX_W.
`timescale 1ns / 1ps
`default_nettype none

module kct_cell import kct_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 16,
  parameter int COUNT_WIDTH = 16,
  parameter int CELL_IDX    = 0,
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int PW = $clog2(TABLE_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cell_ctrl_t             ctrl,
  input  wire logic [KEY_WIDTH-1:0]   cmp_key,
  input  wire logic [INDEX_W-1:0]     rd_index,
  input  wire logic [CW-1:0]          used,
  input  wire logic [PW-1:0]          pos,
  input  wire logic [KEY_WIDTH-1:0]   left_key,
  input  wire logic [COUNT_WIDTH-1:0] left_count,
  input  wire logic                   left_swap,
  input  wire logic [KEY_WIDTH-1:0]   right_key,
  input  wire logic [COUNT_WIDTH-1:0] right_count,
  output logic [KEY_WIDTH-1:0]        key,
  output logic [COUNT_WIDTH-1:0]      count,
  output logic                        swap,
  output logic                        hit
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic IDX_ODD = 1'(CELL_IDX % 2);

  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   hit_r, hit_nxt;
  logic                   valid;
  logic                   pair_live;

  assign valid     = CW'(CELL_IDX) < used;
  // This cell is the left half of a live compare pair in the current phase.
  assign pair_live = (IDX_ODD == ctrl.odd) && (CW'(CELL_IDX + 1) < used);
  assign swap      = (ctrl.op == OP_SORT) && pair_live && (key_r > right_key);

  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    hit_nxt   = hit_r;
    case (ctrl.op)
      OP_LOOK: begin
        if (ctrl.by_index) begin
          hit_nxt = valid && (32'(CELL_IDX) == 32'(rd_index));
        end else begin
          hit_nxt = valid && (key_r == cmp_key);
        end
      end
      OP_UPDATE: begin
        if (hit_r) begin
          if (ctrl.take) begin
            count_nxt = (count_r == '0) ? count_r : count_r - COUNT_WIDTH'(1);
          end else begin
            count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_WIDTH'(1);
          end
        end
      end
      OP_APPEND: begin
        if (CW'(CELL_IDX) == used) begin
          key_nxt   = cmp_key;
          count_nxt = COUNT_WIDTH'(1);
        end
      end
      OP_REMOVE: begin
        if (PW'(CELL_IDX) >= pos) begin
          key_nxt   = right_key;
          count_nxt = right_count;
        end
      end
      OP_SORT: begin
        if (swap) begin
          key_nxt   = right_key;
          count_nxt = right_count;
        end else if (left_swap) begin
          key_nxt   = left_key;
          count_nxt = left_count;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    count_r <= count_nxt;
  end

  assign key   = key_r;
  assign count = count_r;
  assign hit   = hit_r;

endmodule

`default_nettype wire

[design/kct_gather.sv]
// Two-stage registered OR tree that collects the single matching cell.
// Returns found flag, key, count and position; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module kct_gather #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 16,
  parameter int COUNT_WIDTH = 16,
  localparam int PW = $clog2(TABLE_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic [TABLE_DEPTH-1:0] hits,
  input  wire logic [KEY_WIDTH-1:0]   keys   [TABLE_DEPTH],
  input  wire logic [COUNT_WIDTH-1:0] counts [TABLE_DEPTH],
  output logic                        found,
  output logic [KEY_WIDTH-1:0]        key,
  output logic [COUNT_WIDTH-1:0]      count,
  output logic [PW-1:0]               pos
);

  localparam int GROUP = 8;
  localparam int NGRP  = (TABLE_DEPTH + GROUP - 1) / GROUP;

  logic                   grp_hit_r [NGRP];
  logic [KEY_WIDTH-1:0]   grp_key_r [NGRP];
  logic [COUNT_WIDTH-1:0] grp_cnt_r [NGRP];
  logic [PW-1:0]          grp_pos_r [NGRP];
  logic                   grp_hit_nxt [NGRP];
  logic [KEY_WIDTH-1:0]   grp_key_nxt [NGRP];
  logic [COUNT_WIDTH-1:0] grp_cnt_nxt [NGRP];
  logic [PW-1:0]          grp_pos_nxt [NGRP];

  logic                   found_r, found_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;

  // Keys are unique among live entries, so at most one hit is set and a
  // plain OR of the masked fields picks out that entry.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_nxt[g] = 1'b0;
      grp_key_nxt[g] = '0;
      grp_cnt_nxt[g] = '0;
      grp_pos_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < TABLE_DEPTH) begin
          if (hits[g * GROUP + k]) begin
            grp_hit_nxt[g] = 1'b1;
            grp_key_nxt[g] = grp_key_nxt[g] | keys[g * GROUP + k];
            grp_cnt_nxt[g] = grp_cnt_nxt[g] | counts[g * GROUP + k];
            grp_pos_nxt[g] = grp_pos_nxt[g] | PW'(g * GROUP + k);
          end
        end
      end
    end
  end

  always_comb begin
    found_nxt = 1'b0;
    key_nxt   = '0;
    count_nxt = '0;
    pos_nxt   = '0;
    for (int g = 0; g < NGRP; g++) begin
      found_nxt = found_nxt | grp_hit_r[g];
      key_nxt   = key_nxt | grp_key_r[g];
      count_nxt = count_nxt | grp_cnt_r[g];
      pos_nxt   = pos_nxt | grp_pos_r[g];
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_r[g] <= grp_hit_nxt[g];
      grp_key_r[g] <= grp_key_nxt[g];
      grp_cnt_r[g] <= grp_cnt_nxt[g];
      grp_pos_r[g] <= grp_pos_nxt[g];
    end
    found_r <= found_nxt;
    key_r   <= key_nxt;
    count_r <= count_nxt;
    pos_r   <= pos_nxt;
  end

  assign found = found_r;
  assign key   = key_r;
  assign count = count_r;
  assign pos   = pos_r;

endmodule

`default_nettype wire
